>>> hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk_i, held off while rst_ni is low.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("concurrent check failed");

// Concurrent check that a condition never holds.
`define ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`endif

>>> hw/rtl/htcp_pkg.sv
`timescale 1ns / 1ps

package htcp_pkg;

  // Default table size in buckets (power of two, 8 to 256).
  localparam int BucketsDefault = 256;
  // Control bytes per probe group; fixed by the probe scheme.
  localparam int GroupBytes = 8;
  localparam int LaneW = 3;

  localparam logic [7:0] CtrlEmpty   = 8'hFF;
  localparam logic [7:0] CtrlDeleted = 8'h80;
  localparam logic [7:0] MaskReset   = 8'hFF;

  typedef enum logic [1:0] {
    ActWrite  = 2'd0,
    ActInsert = 2'd1,
    ActCand   = 2'd2,
    ActNone   = 2'd3
  } action_e;

endpackage

>>> hw/rtl/hash_table_control_probe.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Payload
// config    in         cfg_we_i                  cfg_wdata_i (bucket mask)
// request   in         start && !busy            action_i, write_index_i, control_byte_i,
//                                                hash_value_i, tag_fragment_i
// result    out        valid_o (one-cycle beat)  kind_o, group_position_o, match_mask_o,
//                                                slot_found_o, table_full_o,
//                                                ended_on_empty_o, last_o
//
// After reset a clearing pass fills the control store with empty bytes, one row
// of all eight banks per cycle, with busy high.
// A write goes to its bank when it is accepted. A probe handles each group by address
// issue, then bank read and compare; when the bucket mask's low three bits are not
// all ones it does so once per lane, as the eight banks must be read one lane at a time.
// Each beat comes in the cycle after its group compare and lasts one; no receiver stall.

`include "assert_macros.svh"

module hash_table_control_probe #(
  parameter int BUCKETS = htcp_pkg::BucketsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] action_i,
  input  logic [7:0] write_index_i,
  input  logic [7:0] control_byte_i,
  input  logic [7:0] hash_value_i,
  input  logic [6:0] tag_fragment_i,
  output logic       valid_o,
  output logic       kind_o,
  output logic [7:0] group_position_o,
  output logic [7:0] match_mask_o,
  output logic [7:0] slot_found_o,
  output logic       table_full_o,
  output logic       ended_on_empty_o,
  output logic       last_o
);

  localparam int NB = htcp_pkg::GroupBytes;
  localparam int LW = htcp_pkg::LaneW;
  localparam int Rows = BUCKETS / NB;
  localparam int RowW = (Rows > 1) ? $clog2(Rows) : 1;
  localparam logic [7:0] IdxMask = 8'(BUCKETS - 1);
  localparam logic [RowW-1:0] LastRow = RowW'(Rows - 1);

  // One-hot sequencer states.
  typedef enum logic [3:0] {
    StClear = 4'b0001,
    StIdle  = 4'b0010,
    StIssue = 4'b0100,
    StCapt  = 4'b1000
  } state_e;

  state_e st_q, st_d;

  logic [7:0]    bucket_mask_q;
  logic [7:0]    pos_q, pos_d;
  logic [8:0]    stride_q, stride_d;
  logic [5:0]    count_q, count_d;
  logic [LW-1:0] lane_q, lane_d;
  logic [RowW-1:0] clr_q, clr_d;
  logic          cand_q, cand_d;
  logic [6:0]    tag_q, tag_d;
  logic [7:0]    grp_q [NB];

  logic       valid_q, valid_d;
  logic       kind_q, kind_d;
  logic [7:0] gpos_q, gpos_d;
  logic [7:0] mm_q, mm_d;
  logic [7:0] slot_q, slot_d;
  logic       full_q, full_d;
  logic       empty_q, empty_d;
  logic       last_q, last_d;

  // Bank ports: bucket a lives in bank a[2:0], row a >> 3.
  logic            bank_we    [NB];
  logic [RowW-1:0] bank_waddr;
  logic [7:0]      bank_wdata;
  logic [RowW-1:0] bank_raddr [NB];
  logic [7:0]      bank_rdata [NB];

  logic [7:0] eff_mask;
  logic [5:0] probe_limit;
  logic       slow;
  logic       accept;
  htcp_pkg::action_e act;

  logic [7:0] lane_addr [NB];
  logic       lane_act  [NB];
  logic [7:0] grp_byte  [NB];

  logic          hit;
  logic [LW-1:0] hit_idx;
  logic [7:0]    tag_mm;
  logic          has_empty;
  logic [8:0]    stride_nx;
  logic [7:0]    pos_nx;
  logic [5:0]    count_nx;
  logic          last_grp;

  assign eff_mask    = bucket_mask_q & IdxMask;
  assign probe_limit = 6'(((9'({1'b0, eff_mask}) + 9'd1) >> 3) + 9'd1);
  // A mask whose low three bits are not all ones may map two lanes to one bank.
  assign slow        = (eff_mask[2:0] != 3'b111);
  assign busy        = (st_q != StIdle);
  assign accept      = start && !busy;
  assign act         = htcp_pkg::action_e'(action_i);

  function automatic logic [RowW-1:0] row_of(input logic [7:0] a);
    return RowW'(a >> 3);
  endfunction

  // Lane addresses of the current group, wrapped by the mask.
  always_comb begin
    for (int i = 0; i < NB; i++) begin
      lane_addr[i] = (pos_q + 8'(i)) & eff_mask;
      lane_act[i]  = !slow || (lane_q == LW'(i));
    end
  end

  // Route each active lane to the bank that holds its byte.
  always_comb begin
    for (int b = 0; b < NB; b++) begin
      bank_raddr[b] = '0;
      for (int i = 0; i < NB; i++) begin
        if (lane_act[i] && (lane_addr[i][2:0] == LW'(b))) begin
          bank_raddr[b] = row_of(lane_addr[i]);
        end
      end
    end
  end

  // Write side: clearing pass fills all banks of a row, a write beat one bank.
  always_comb begin
    for (int b = 0; b < NB; b++) begin
      bank_we[b] = 1'b0;
    end
    bank_waddr = row_of(write_index_i & IdxMask);
    bank_wdata = control_byte_i;
    if (st_q == StClear) begin
      for (int b = 0; b < NB; b++) begin
        bank_we[b] = 1'b1;
      end
      bank_waddr = clr_q;
      bank_wdata = htcp_pkg::CtrlEmpty;
    end else if (accept && (act == htcp_pkg::ActWrite)) begin
      bank_we[write_index_i[2:0]] = 1'b1;
    end
  end

  for (genvar g = 0; g < NB; g++) begin : g_bank
    htcp_ram #(
      .WIDTH(8),
      .DEPTH(Rows)
    ) u_bank (
      .clk_i  (clk_i),
      .we_i   (bank_we[g]),
      .waddr_i(bank_waddr),
      .wdata_i(bank_wdata),
      .raddr_i(bank_raddr[g]),
      .rdata_o(bank_rdata[g])
    );
  end

  // Group compare: fresh bank data for active lanes, held bytes for the rest.
  always_comb begin
    hit       = 1'b0;
    hit_idx   = '0;
    tag_mm    = '0;
    has_empty = 1'b0;
    for (int i = 0; i < NB; i++) begin
      grp_byte[i] = lane_act[i] ? bank_rdata[lane_addr[i][2:0]] : grp_q[i];
      tag_mm[i]   = (grp_byte[i] == {1'b0, tag_q});
      if (grp_byte[i] == htcp_pkg::CtrlEmpty) begin
        has_empty = 1'b1;
      end
    end
    // Lowest lane with the top bit set (empty or deleted) wins.
    for (int i = NB - 1; i >= 0; i--) begin
      if ((grp_byte[i] & htcp_pkg::CtrlDeleted) != 8'h00) begin
        hit     = 1'b1;
        hit_idx = LW'(i);
      end
    end
  end

  // Triangular step to the next group.
  assign stride_nx = stride_q + 9'(NB);
  assign pos_nx    = (pos_q + stride_nx[7:0]) & eff_mask;
  assign count_nx  = count_q + 6'd1;
  assign last_grp  = (count_nx >= probe_limit);

  always_comb begin
    st_d     = st_q;
    pos_d    = pos_q;
    stride_d = stride_q;
    count_d  = count_q;
    lane_d   = lane_q;
    clr_d    = clr_q;
    cand_d   = cand_q;
    tag_d    = tag_q;
    valid_d  = 1'b0;
    kind_d   = kind_q;
    gpos_d   = gpos_q;
    mm_d     = mm_q;
    slot_d   = slot_q;
    full_d   = full_q;
    empty_d  = empty_q;
    last_d   = last_q;
    case (st_q)
      StClear: begin
        clr_d = clr_q + RowW'(1);
        if (clr_q == LastRow) begin
          st_d = StIdle;
        end
      end
      StIdle: begin
        if (accept && ((act == htcp_pkg::ActInsert) || (act == htcp_pkg::ActCand))) begin
          pos_d    = hash_value_i & eff_mask;
          stride_d = '0;
          count_d  = '0;
          lane_d   = '0;
          cand_d   = (act == htcp_pkg::ActCand);
          tag_d    = tag_fragment_i;
          st_d     = StIssue;
        end
      end
      StIssue: begin
        st_d = StCapt;
      end
      StCapt: begin
        if (slow && (lane_q != LW'(NB - 1))) begin
          // Gather one more lane before comparing.
          lane_d = lane_q + LW'(1);
          st_d   = StIssue;
        end else begin
          lane_d = '0;
          gpos_d = pos_q;
          if (!cand_q) begin
            kind_d  = 1'b0;
            mm_d    = '0;
            empty_d = 1'b0;
            if (hit) begin
              valid_d = 1'b1;
              slot_d  = lane_addr[hit_idx];
              full_d  = 1'b0;
              last_d  = 1'b1;
              st_d    = StIdle;
            end else if (last_grp) begin
              valid_d = 1'b1;
              slot_d  = '0;
              full_d  = 1'b1;
              last_d  = 1'b1;
              st_d    = StIdle;
            end else begin
              st_d = StIssue;
            end
          end else begin
            valid_d = 1'b1;
            kind_d  = 1'b1;
            mm_d    = tag_mm;
            slot_d  = '0;
            full_d  = 1'b0;
            empty_d = has_empty;
            last_d  = has_empty || last_grp;
            st_d    = (has_empty || last_grp) ? StIdle : StIssue;
          end
          // Advance the walk unless it ends on this group.
          if (st_d == StIssue) begin
            stride_d = stride_nx;
            pos_d    = pos_nx;
            count_d  = count_nx;
          end
        end
      end
      default: begin
        st_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q          <= StClear;
      bucket_mask_q <= htcp_pkg::MaskReset;
      pos_q         <= '0;
      stride_q      <= '0;
      count_q       <= '0;
      lane_q        <= '0;
      clr_q         <= '0;
      cand_q        <= 1'b0;
      valid_q       <= 1'b0;
    end else begin
      st_q     <= st_d;
      pos_q    <= pos_d;
      stride_q <= stride_d;
      count_q  <= count_d;
      lane_q   <= lane_d;
      clr_q    <= clr_d;
      cand_q   <= cand_d;
      valid_q  <= valid_d;
      if (cfg_we_i) begin
        bucket_mask_q <= cfg_wdata_i;
      end
    end
  end

  // Payload: no reset needed.
  always_ff @(posedge clk_i) begin
    tag_q   <= tag_d;
    kind_q  <= kind_d;
    gpos_q  <= gpos_d;
    mm_q    <= mm_d;
    slot_q  <= slot_d;
    full_q  <= full_d;
    empty_q <= empty_d;
    last_q  <= last_d;
    if (st_q == StCapt) begin
      for (int i = 0; i < NB; i++) begin
        grp_q[i] <= grp_byte[i];
      end
    end
  end

  assign valid_o          = valid_q;
  assign kind_o           = kind_q;
  assign group_position_o = gpos_q;
  assign match_mask_o     = mm_q;
  assign slot_found_o     = slot_q;
  assign table_full_o     = full_q;
  assign ended_on_empty_o = empty_q;
  assign last_o           = last_q;

  // An insert answer is always the one and final beat of its request.
  `ASSERT_CLK(a_insert_last, (valid_o && !kind_o) |-> last_o)
  // A beat that is not final means the walk is still running.
  `ASSERT_CLK(a_more_busy, (valid_o && !last_o) |-> busy)
  // Each group passes through the issue state, so beats never come back to back.
  `ASSERT_CLK(a_beat_gap, valid_o |=> !valid_o)
  // Bank data is only compared in the cycle after its address went out.
  `ASSERT_CLK(a_capt_after_issue, (st_q == StCapt) |-> ($past(st_q) == StIssue))

endmodule

>>> hw/rtl/htcp_ram.sv
`timescale 1ns / 1ps

module htcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
